// ===== src/vat_pkg.sv =====
// Shared types, constants and trig ROM for the 2D vertex affine transform.
// No dependencies; imported by every module of the block.
package vat_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int ROM_FRAC       = 14;
  localparam int SCALE_WIDTH    = 16;
  localparam int OFFSET_WIDTH   = 16;
  localparam int ANGLE_WIDTH    = 9;
  localparam int PADDR_WIDTH    = 5;
  localparam int PDATA_WIDTH    = 32;

  localparam int TRIG_UP  = (TRIG_FRAC_BITS >= ROM_FRAC) ? TRIG_FRAC_BITS - ROM_FRAC : 0;
  localparam int TRIG_DN  = (TRIG_FRAC_BITS <  ROM_FRAC) ? ROM_FRAC - TRIG_FRAC_BITS : 0;
  localparam int TRIG_RND = (TRIG_DN > 0) ? (1 << (TRIG_DN - 1)) : 0;

  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int PROD_W = COORD_WIDTH + SCALE_WIDTH + 1;
  localparam int XS_W   = PROD_W - 7;
  localparam int MUL_W  = XS_W + TRIG_W;
  localparam int SUM_W  = MUL_W + 1;
  localparam int ROT_W  = SUM_W - TRIG_FRAC_BITS;
  localparam int FIN_W  = ROT_W + 2;

  typedef enum logic [2:0] {
    REG_SCALE_X  = 3'd0,
    REG_SCALE_Y  = 3'd1,
    REG_ANGLE    = 3'd2,
    REG_MIRROR_X = 3'd3,
    REG_MIRROR_Y = 3'd4,
    REG_OFFSET_X = 3'd5,
    REG_OFFSET_Y = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [SCALE_WIDTH-1:0]         scale_x;
    logic [SCALE_WIDTH-1:0]         scale_y;
    logic [ANGLE_WIDTH-1:0]         angle_deg;
    logic                           mirror_x;
    logic                           mirror_y;
    logic signed [OFFSET_WIDTH-1:0] offset_x;
    logic signed [OFFSET_WIDTH-1:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_val;
    logic signed [TRIG_W-1:0] cos_val;
  } trig_t;

  localparam logic [ROM_FRAC:0] QUARTER_SINE [91] = '{
        15'd0,   15'd286,   15'd572,   15'd857,  15'd1143,  15'd1428,  15'd1713,  15'd1997,
     15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,  15'd4240,
     15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,  15'd5872,  15'd6138,  15'd6402,
     15'd6664,  15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,  15'd8192,  15'd8438,
     15'd8682,  15'd8923,  15'd9162,  15'd9397,  15'd9630,  15'd9860, 15'd10087, 15'd10311,
    15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
    15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
    15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491,
    15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
    15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294, 15'd16322, 15'd16344, 15'd16362,
    15'd16374, 15'd16382, 15'd16384
  };

  function automatic logic signed [TRIG_W-1:0] rescale_trig(input logic [ROM_FRAC:0] mag);
    logic [TRIG_W+ROM_FRAC:0] wide;
    wide = {{TRIG_W{1'b0}}, mag};
    if (TRIG_FRAC_BITS >= ROM_FRAC) begin
      wide = wide << TRIG_UP;
    end else begin
      wide = (wide + (TRIG_W + ROM_FRAC + 1)'(TRIG_RND)) >> TRIG_DN;
    end
    return $signed(wide[TRIG_W-1:0]);
  endfunction

  // a in 0..359
  function automatic logic signed [TRIG_W-1:0] sine_deg(input logic [ANGLE_WIDTH-1:0] a);
    logic [ANGLE_WIDTH-1:0]   idx;
    logic signed [TRIG_W-1:0] mag;
    if (a <= 9'd90) begin
      idx = a;
    end else if (a <= 9'd180) begin
      idx = 9'd180 - a;
    end else if (a <= 9'd270) begin
      idx = a - 9'd180;
    end else begin
      idx = 9'd360 - a;
    end
    mag = rescale_trig(QUARTER_SINE[idx[6:0]]);
    return (a > 9'd180) ? -mag : mag;
  endfunction

endpackage

// ===== src/vat_regs.sv =====
// APB configuration register file for the vertex transform.
// Depends on vat_pkg for register indexes and the cfg_t bundle.
module vat_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vat_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [vat_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [vat_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                            pready,
  output vat_pkg::cfg_t                   cfg
);
  import vat_pkg::*;

  reg_index_t idx;
  logic       wr_en;

  assign idx    = reg_index_t'(paddr[PADDR_WIDTH-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_x   <= SCALE_WIDTH'(256);
      cfg.scale_y   <= SCALE_WIDTH'(256);
      cfg.angle_deg <= '0;
      cfg.mirror_x  <= 1'b0;
      cfg.mirror_y  <= 1'b0;
      cfg.offset_x  <= '0;
      cfg.offset_y  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SCALE_X:  cfg.scale_x   <= pwdata[SCALE_WIDTH-1:0];
        REG_SCALE_Y:  cfg.scale_y   <= pwdata[SCALE_WIDTH-1:0];
        REG_ANGLE:    cfg.angle_deg <= pwdata[ANGLE_WIDTH-1:0];
        REG_MIRROR_X: cfg.mirror_x  <= pwdata[0];
        REG_MIRROR_Y: cfg.mirror_y  <= pwdata[0];
        REG_OFFSET_X: cfg.offset_x  <= $signed(pwdata[OFFSET_WIDTH-1:0]);
        REG_OFFSET_Y: cfg.offset_y  <= $signed(pwdata[OFFSET_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SCALE_X:  prdata = PDATA_WIDTH'(cfg.scale_x);
      REG_SCALE_Y:  prdata = PDATA_WIDTH'(cfg.scale_y);
      REG_ANGLE:    prdata = PDATA_WIDTH'(cfg.angle_deg);
      REG_MIRROR_X: prdata = PDATA_WIDTH'(cfg.mirror_x);
      REG_MIRROR_Y: prdata = PDATA_WIDTH'(cfg.mirror_y);
      REG_OFFSET_X: prdata = PDATA_WIDTH'($unsigned(cfg.offset_x));
      REG_OFFSET_Y: prdata = PDATA_WIDTH'($unsigned(cfg.offset_y));
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== src/vat_trig.sv =====
// Sine and cosine of the configured angle, registered from the quarter-wave ROM.
// Depends on vat_pkg for the ROM and sine_deg.
module vat_trig (
  input  logic                            clk,
  input  logic [vat_pkg::ANGLE_WIDTH-1:0] angle_deg,
  output vat_pkg::trig_t                  trig
);
  import vat_pkg::*;

  logic [ANGLE_WIDTH-1:0] a_red;
  logic [ANGLE_WIDTH:0]   a_cos_raw;
  logic [ANGLE_WIDTH-1:0] a_cos;

  // reduce once by 360
  assign a_red     = (angle_deg >= 9'd360) ? angle_deg - 9'd360 : angle_deg;
  assign a_cos_raw = {1'b0, a_red} + 10'd90;
  assign a_cos     = (a_cos_raw >= 10'd360) ? ANGLE_WIDTH'(a_cos_raw - 10'd360)
                                            : a_cos_raw[ANGLE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    trig.sin_val <= sine_deg(a_red);
    trig.cos_val <= sine_deg(a_cos);
  end

endmodule

// ===== src/vat_pipe.sv =====
// Five-stage datapath: scale, round, rotate multiply, rotate sum and mirror,
// offset and saturate. Depends on vat_pkg; trig values come from vat_trig.
module vat_pipe (
  input  logic                                   clk,
  input  logic                                   rst,
  input  vat_pkg::cfg_t                          cfg,
  input  vat_pkg::trig_t                         trig,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [vat_pkg::COORD_WIDTH-1:0] in_x,
  input  logic signed [vat_pkg::COORD_WIDTH-1:0] in_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [vat_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [vat_pkg::COORD_WIDTH-1:0] out_y,
  output logic                                   out_sat
);
  import vat_pkg::*;

  localparam int NSTG = 5;
  localparam logic signed [FIN_W-1:0] SAT_HI = FIN_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [FIN_W-1:0] SAT_LO = -SAT_HI - FIN_W'(1);
  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(64'sd1 <<< (TRIG_FRAC_BITS - 1));
  localparam logic signed [PROD_W:0]  RND8   = (PROD_W + 1)'(128);

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;

  logic signed [PROD_W-1:0] p1_x, p1_y;
  logic signed [XS_W-1:0]   s2_x, s2_y;
  trig_t                    s2_trig;
  logic signed [MUL_W-1:0]  m3_xc, m3_ys, m3_xs, m3_yc;
  logic signed [ROT_W:0]    r4_x, r4_y;

  logic signed [PROD_W:0]   rnd_x, rnd_y;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic signed [ROT_W-1:0]  rot_x, rot_y;
  logic signed [FIN_W-1:0]  fin_x, fin_y;
  logic                     hi_x, lo_x, hi_y, lo_y;

  assign rdy[NSTG] = out_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign rnd_x = (PROD_W + 1)'(p1_x) + RND8;
  assign rnd_y = (PROD_W + 1)'(p1_y) + RND8;

  assign sum_x = SUM_W'(m3_xc) - SUM_W'(m3_ys) + HALF;
  assign sum_y = SUM_W'(m3_xs) + SUM_W'(m3_yc) + HALF;
  assign rot_x = sum_x[SUM_W-1:TRIG_FRAC_BITS];
  assign rot_y = sum_y[SUM_W-1:TRIG_FRAC_BITS];

  assign fin_x = FIN_W'(r4_x) + FIN_W'(cfg.offset_x);
  assign fin_y = FIN_W'(r4_y) + FIN_W'(cfg.offset_y);
  assign hi_x  = fin_x > SAT_HI;
  assign lo_x  = fin_x < SAT_LO;
  assign hi_y  = fin_y > SAT_HI;
  assign lo_y  = fin_y < SAT_LO;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p1_x <= in_x * $signed({1'b0, cfg.scale_x});
      p1_y <= in_y * $signed({1'b0, cfg.scale_y});
    end
    if (rdy[1]) begin
      s2_x    <= rnd_x[PROD_W:8];
      s2_y    <= rnd_y[PROD_W:8];
      s2_trig <= trig;
    end
    if (rdy[2]) begin
      m3_xc <= s2_x * s2_trig.cos_val;
      m3_ys <= s2_y * s2_trig.sin_val;
      m3_xs <= s2_x * s2_trig.sin_val;
      m3_yc <= s2_y * s2_trig.cos_val;
    end
    if (rdy[3]) begin
      r4_x <= cfg.mirror_x ? -(ROT_W + 1)'(rot_x) : (ROT_W + 1)'(rot_x);
      r4_y <= cfg.mirror_y ? -(ROT_W + 1)'(rot_y) : (ROT_W + 1)'(rot_y);
    end
    if (rdy[4]) begin
      out_x   <= hi_x ? SAT_HI[COORD_WIDTH-1:0] : lo_x ? SAT_LO[COORD_WIDTH-1:0]
                                                  : fin_x[COORD_WIDTH-1:0];
      out_y   <= hi_y ? SAT_HI[COORD_WIDTH-1:0] : lo_y ? SAT_LO[COORD_WIDTH-1:0]
                                                  : fin_y[COORD_WIDTH-1:0];
      out_sat <= hi_x || lo_x || hi_y || lo_y;
    end
  end

endmodule

// ===== src/vertex_affine_transform_2d.sv =====
// Top level of the 2D vertex affine transform: scale, rotate, mirror, offset.
// One vertex per cycle while the result side is not stalled by result_ready.
// Each pipeline stage holds while its successor is full and stalled.
// Reset (rst, synchronous) empties the pipeline and loads default registers.
// Uses vat_pkg, vat_regs, vat_trig and vat_pipe.
module vertex_affine_transform_2d (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [vat_pkg::PADDR_WIDTH-1:0]        paddr,
  input  logic [vat_pkg::PDATA_WIDTH-1:0]        pwdata,
  output logic [vat_pkg::PDATA_WIDTH-1:0]        prdata,
  output logic                                   pready,
  input  logic                                   vertex_valid,
  output logic                                   vertex_ready,
  input  logic signed [vat_pkg::COORD_WIDTH-1:0] vertex_x,
  input  logic signed [vat_pkg::COORD_WIDTH-1:0] vertex_y,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic signed [vat_pkg::COORD_WIDTH-1:0] result_x,
  output logic signed [vat_pkg::COORD_WIDTH-1:0] result_y,
  output logic                                   saturated
);
  import vat_pkg::*;

  cfg_t  cfg;
  trig_t trig;

  vat_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vat_trig u_trig (
    .clk       (clk),
    .angle_deg (cfg.angle_deg),
    .trig      (trig)
  );

  vat_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .trig      (trig),
    .in_valid  (vertex_valid),
    .in_ready  (vertex_ready),
    .in_x      (vertex_x),
    .in_y      (vertex_y),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_x     (result_x),
    .out_y     (result_y),
    .out_sat   (saturated)
  );

endmodule

// ===== src/vat_checker.sv =====
// Port-level checks for vertex_affine_transform_2d, attached by bind.
// Depends on vat_pkg for the coordinate width.
module vat_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   vertex_ready,
  input logic                                   result_valid,
  input logic                                   result_ready,
  input logic signed [vat_pkg::COORD_WIDTH-1:0] result_x,
  input logic signed [vat_pkg::COORD_WIDTH-1:0] result_y,
  input logic                                   saturated
);
  import vat_pkg::*;

  localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_x)
      && $stable(result_y) && $stable(saturated))
    else $error("stalled result transaction changed");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> result_x == CMAX || result_x == CMIN
      || result_y == CMAX || result_y == CMIN)
    else $error("saturation flag without a clipped coordinate");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> vertex_ready)
    else $error("vertex transaction refused with empty output");

endmodule

bind vertex_affine_transform_2d vat_checker u_vat_checker (
  .clk          (clk),
  .rst          (rst),
  .vertex_ready (vertex_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_x     (result_x),
  .result_y     (result_y),
  .saturated    (saturated)
);
